### hdl/passband_signal_level_meter_core_assert.svh
// Assertion macros used by the level meter back end (plm_back).
// The file that uses them declares clk and rst.
`ifndef PASSBAND_SIGNAL_LEVEL_METER_CORE_ASSERT_SVH
`define PASSBAND_SIGNAL_LEVEL_METER_CORE_ASSERT_SVH

// same-cycle implication
`define PLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/plm_pkg.sv
`default_nettype none
package plm_pkg;

  localparam int MAG_W  = 24;
  localparam int SUM_W  = 36;
  localparam int CFG_W  = 17;
  localparam int ADDR_W = 3;
  localparam int EDGE_W = 19;
  localparam int NUM_W  = 18;
  localparam int AVG_W  = 26;
  localparam int OUT_W  = 17;
  localparam int LOG_W  = 22;
  localparam int Q8_W   = 19;
  localparam int QDEPTH = 2;
  localparam int HOLD   = 3;

  localparam int BINS_DEF = 256;
  localparam int RATE_DEF = 96000;

  localparam logic [17:0]           LOG_SCALE      = 18'd197283;
  localparam logic signed [Q8_W-1:0] Q816_OFFSET   = 19'sd12330;
  localparam logic signed [Q8_W-1:0] CONS_Q8       = -19'sd23552;
  localparam logic signed [Q8_W-1:0] QUIET_LVL_Q8  = -19'sd35840;
  localparam logic signed [Q8_W-1:0] QUIET_DENS_Q8 = -19'sd42240;
  localparam logic signed [AVG_W-1:0] AVG_LVL_RST  = -26'sd4784128;
  localparam logic signed [AVG_W-1:0] AVG_DENS_RST = -26'sd6750208;

  typedef enum logic [ADDR_W-1:0] {
    REG_DEMOD = 3'd0,
    REG_FHIGH = 3'd1,
    REG_FLOW  = 3'd2,
    REG_CAL   = 3'd3,
    REG_ATTEN = 3'd4,
    REG_ATK   = 3'd5,
    REG_DEC   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_USB = 2'd0,
    MODE_LSB = 2'd1,
    MODE_DSB = 2'd2
  } demod_t;

  typedef struct packed {
    logic [1:0]         demod_mode;
    logic signed [16:0] filter_high;
    logic signed [16:0] filter_low;
    logic signed [15:0] cal;
    logic signed [7:0]  atten;
    logic [15:0]        atk_alpha;
    logic [15:0]        dec_alpha;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE, B_NORM, B_SQR, B_SCALE, B_LEVEL, B_MUL, B_ACC, B_MAX, B_OUT
  } back_state_t;

  // round Q10.16 to Q9.8 and saturate to 17 bits
  function automatic logic [OUT_W-1:0] sat17(input logic signed [AVG_W-1:0] avg);
    logic signed [AVG_W:0] r;
    logic signed [AVG_W-8:0] v;
    r = {avg[AVG_W-1], avg} + 27'sd128;
    v = r[AVG_W:8];
    if (v > 19'sd65535) begin
      sat17 = 17'h0FFFF;
    end else if (v < -19'sd65536) begin
      sat17 = 17'h10000;
    end else begin
      sat17 = v[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

### hdl/plm_queue.sv
`default_nettype none
module plm_queue import plm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [SUM_W-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [SUM_W-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = $clog2(QDEPTH);

  logic [SUM_W-1:0] mem [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### hdl/plm_front.sv
`default_nettype none
module plm_front import plm_pkg::*; #(
  parameter int BINS           = BINS_DEF,
  parameter int SAMPLE_RATE_HZ = RATE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             cfg_we,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [MAG_W-1:0] in_mag,
  input  wire logic             in_last,
  output logic                  push,
  output logic [SUM_W-1:0]      push_sum,
  input  wire logic             q_full
);
  localparam int CW     = $clog2(BINS);
  localparam int W      = (SAMPLE_RATE_HZ / BINS < 1) ? 1 : SAMPLE_RATE_HZ / BINS;
  localparam int D      = 2 * W;
  localparam int SH     = NUM_W + $clog2(D);
  localparam int RW     = NUM_W + 2;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + D - 1) / D;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic signed [EDGE_W-1:0] QUARTER = EDGE_W'(BINS / 4);
  localparam logic signed [EDGE_W-1:0] TOP_BIN = EDGE_W'(BINS - 1);

  // stage 1: edge select, magnitude, rounding numerator
  logic signed [EDGE_W-1:0] a_s;
  logic signed [EDGE_W-1:0] b_s;
  logic [NUM_W-1:0] a_num;
  logic [NUM_W-1:0] b_num;
  logic             a_neg;
  logic             b_neg;
  // stage 2: reciprocal multiply
  logic signed [EDGE_W-1:0] l_raw;
  logic signed [EDGE_W-1:0] u_raw;
  // stage 3: clamped bounds
  logic signed [EDGE_W-1:0] lo_bin;
  logic signed [EDGE_W-1:0] hi_bin;
  logic [1:0]     hold;
  logic [CW-1:0]  bin_cnt;
  logic [SUM_W-1:0] band_sum;

  logic [NUM_W+RW-1:0] a_prod;
  logic [NUM_W+RW-1:0] b_prod;
  logic signed [EDGE_W-1:0] a_q;
  logic signed [EDGE_W-1:0] b_q;
  logic signed [EDGE_W-1:0] l_c;
  logic signed [EDGE_W-1:0] u_c;
  logic signed [EDGE_W-1:0] cnt_s;
  logic in_band;
  logic accept;
  logic [SUM_W-1:0] sum_new;

  always_comb begin
    case (cfg.demod_mode)
      MODE_USB: begin
        a_s = -EDGE_W'(cfg.filter_high);
        b_s = -EDGE_W'(cfg.filter_low);
      end
      MODE_LSB: begin
        a_s = EDGE_W'(cfg.filter_low);
        b_s = EDGE_W'(cfg.filter_high);
      end
      default: begin
        a_s = -EDGE_W'(cfg.filter_high);
        b_s = EDGE_W'(cfg.filter_high);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_neg <= a_s[EDGE_W-1];
    b_neg <= b_s[EDGE_W-1];
    a_num <= {(a_s[EDGE_W-1] ? (NUM_W-1)'(-a_s) : (NUM_W-1)'(a_s)), 1'b0} + NUM_W'(W);
    b_num <= {(b_s[EDGE_W-1] ? (NUM_W-1)'(-b_s) : (NUM_W-1)'(b_s)), 1'b0} + NUM_W'(W);
  end

  // round(x / W) = (2|x| + W) / 2W, done by exact reciprocal
  assign a_prod = (NUM_W+RW)'(a_num) * (NUM_W+RW)'(RECIP);
  assign b_prod = (NUM_W+RW)'(b_num) * (NUM_W+RW)'(RECIP);
  assign a_q    = EDGE_W'(a_prod >> SH);
  assign b_q    = EDGE_W'(b_prod >> SH);

  always_ff @(posedge clk) begin
    l_raw <= QUARTER + (a_neg ? -a_q : a_q);
    u_raw <= QUARTER + (b_neg ? -b_q : b_q);
  end

  always_comb begin
    l_c = (l_raw < 0) ? '0 : l_raw;
    u_c = (u_raw > TOP_BIN) ? TOP_BIN : u_raw;
    if (l_c == u_c) u_c = l_c + 1'b1;
  end

  always_ff @(posedge clk) begin
    lo_bin <= l_c;
    hi_bin <= u_c;
  end

  assign in_ready = (hold == '0) && !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_s    = EDGE_W'(bin_cnt);
  assign in_band  = (cnt_s >= lo_bin) && (cnt_s <= hi_bin);
  assign sum_new  = band_sum + (in_band ? SUM_W'(in_mag) : '0);
  assign push     = accept && in_last;
  assign push_sum = sum_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold     <= 2'(HOLD);
      bin_cnt  <= '0;
      band_sum <= '0;
    end else begin
      if (cfg_we) begin
        hold <= 2'(HOLD);
      end else if (hold != '0) begin
        hold <= hold - 1'b1;
      end
      if (accept) begin
        if (in_last) begin
          bin_cnt  <= '0;
          band_sum <= '0;
        end else begin
          band_sum <= sum_new;
          if (bin_cnt != CW'(BINS - 1)) bin_cnt <= bin_cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/plm_back.sv
`default_nettype none
`include "passband_signal_level_meter_core_assert.svh"
module plm_back import plm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             q_empty,
  input  wire logic [SUM_W-1:0] q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_level,
  output logic [OUT_W-1:0]      out_density,
  output logic                  out_present
);
  back_state_t state;
  back_state_t state_next;

  logic [SUM_W-1:0] xv;
  logic [5:0]       expo;
  logic [30:0]      mant;
  logic [15:0]      frac;
  logic [3:0]       iter;
  logic [LOG_W+17:0] tprod;
  logic             present;
  logic signed [AVG_W-1:0] lvl;
  logic signed [AVG_W-1:0] dens;
  logic signed [AVG_W-1:0] avg_q [4];
  logic [1:0]       sel;
  logic signed [AVG_W+17:0] mprod;
  logic             load_out;

  logic [61:0]      sq;
  logic [31:0]      sq_s;
  logic [LOG_W+17:0] tsum;
  logic signed [Q8_W-1:0] lvl_q8;
  logic signed [AVG_W-1:0] x_sel;
  logic [15:0]      alpha_sel;
  logic signed [AVG_W:0] diff;
  logic signed [AVG_W+17:0] rnd;

  assign sq   = 62'(mant) * 62'(mant);
  assign sq_s = sq[61:30];
  assign tsum = tprod + (LOG_W+18)'(1 << 23);
  assign lvl_q8 = Q8_W'(cfg.cal) + Q8_W'($signed({cfg.atten, 8'h00}))
                + Q8_W'(tsum[LOG_W+17:24]) - Q816_OFFSET + CONS_Q8;
  assign x_sel     = sel[1] ? dens : lvl;
  assign alpha_sel = sel[0] ? cfg.dec_alpha : cfg.atk_alpha;
  assign diff      = (AVG_W+1)'(x_sel) - (AVG_W+1)'(avg_q[sel]);
  assign rnd       = mprod + (AVG_W+18)'(32768);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty) state_next = (q_data != '0) ? B_NORM : B_LEVEL;
      B_NORM:  if (xv[SUM_W-1]) state_next = B_SQR;
      B_SQR:   if (iter == 4'd15) state_next = B_SCALE;
      B_SCALE: state_next = B_LEVEL;
      B_LEVEL: state_next = B_MUL;
      B_MUL:   state_next = B_ACC;
      B_ACC:   state_next = (sel == 2'd3) ? B_MAX : B_MUL;
      B_MAX:   state_next = B_OUT;
      B_OUT:   if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE:  pop = !q_empty;
      B_OUT:   load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      avg_q[0]  <= AVG_LVL_RST;
      avg_q[1]  <= AVG_LVL_RST;
      avg_q[2]  <= AVG_DENS_RST;
      avg_q[3]  <= AVG_DENS_RST;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == B_ACC) begin
        avg_q[sel] <= avg_q[sel] + AVG_W'(rnd >>> 16);
      end
      if (state == B_MAX) begin
        if (avg_q[0] > avg_q[1]) avg_q[1] <= avg_q[0];
        if (avg_q[2] > avg_q[3]) avg_q[3] <= avg_q[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        xv      <= q_data;
        present <= (q_data != '0);
        expo    <= 6'(SUM_W - 1);
      end
      B_NORM: begin
        if (xv[SUM_W-1]) begin
          mant <= xv[SUM_W-1:SUM_W-31];
          frac <= '0;
          iter <= '0;
        end else begin
          xv   <= xv << 1;
          expo <= expo - 1'b1;
        end
      end
      B_SQR: begin
        frac <= {frac[14:0], sq_s[31]};
        mant <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
        iter <= iter + 1'b1;
      end
      B_SCALE: tprod <= (LOG_W+18)'({expo, frac}) * (LOG_W+18)'(LOG_SCALE);
      B_LEVEL: begin
        sel <= '0;
        if (present) begin
          lvl  <= AVG_W'({lvl_q8, 8'h00});
          dens <= '0;
        end else begin
          lvl  <= AVG_W'({QUIET_LVL_Q8, 8'h00});
          dens <= AVG_W'({QUIET_DENS_Q8, 8'h00});
        end
      end
      B_MUL: mprod <= $signed({1'b0, alpha_sel}) * diff;
      B_ACC: sel <= sel + 1'b1;
      B_OUT: begin
        if (load_out) begin
          out_level   <= sat17(avg_q[1]);
          out_density <= sat17(avg_q[3]);
          out_present <= present;
        end
      end
      default: ;
    endcase
  end

  `PLM_ASSERT_NOW(a_norm_nonzero, state == B_NORM, xv != '0, "normalize on zero sum")
  `PLM_ASSERT_NEXT(a_sqr_count, state == B_SQR && iter == 4'd15, state == B_SCALE,
    "log iteration count wrong")
  `PLM_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == B_OUT,
    "result raised outside done state")
endmodule
`default_nettype wire

### hdl/passband_signal_level_meter_core.sv
// Channel   Dir  Data                                              Marker
// s_axis    in   s_tdata[23:0] bin_magnitude                       s_tlast = last_bin
// m_axis    out  m_tdata level_dbm, level_density, signal_present  -
// cfg       in   cfg_addr register index, cfg_data value           cfg_we
//
// Front takes one bin per cycle unless the queue is full or a register write settles.
// Back works on one frame sum at a time: a leading-one shift, the log2 squaring
// loop, then the four averagers (one multiplier); a zero-sum frame skips the
// shift and the log.
// A 2-entry queue holds finished frame sums; the front stalls when it is full.
// Reset: synchronous; the front holds off input after reset or any register write
// while the band bounds pipeline settles.
`default_nettype none
module passband_signal_level_meter_core import plm_pkg::*; #(
  parameter int BINS           = BINS_DEF,
  parameter int SAMPLE_RATE_HZ = RATE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [MAG_W-1:0]  s_tdata,   // [23:0] bin_magnitude
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [39:0]            m_tdata,   // [16:0] level_dbm, [33:17] level_density,
                                            // [34] signal_present, rest zero
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_data
);
  cfg_t cfg;

  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  logic [SUM_W-1:0] q_data;
  logic [OUT_W-1:0] out_level;
  logic [OUT_W-1:0] out_density;
  logic             out_present;

  // register file, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.demod_mode  <= MODE_USB;
      cfg.filter_high <= '0;
      cfg.filter_low  <= '0;
      cfg.cal         <= 16'sd768;
      cfg.atten       <= '0;
      cfg.atk_alpha   <= 16'd26214;
      cfg.dec_alpha   <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEMOD: cfg.demod_mode  <= cfg_data[1:0];
        REG_FHIGH: cfg.filter_high <= cfg_data;
        REG_FLOW:  cfg.filter_low  <= cfg_data;
        REG_CAL:   cfg.cal         <= cfg_data[15:0];
        REG_ATTEN: cfg.atten       <= cfg_data[7:0];
        REG_ATK:   cfg.atk_alpha   <= cfg_data[15:0];
        REG_DEC:   cfg.dec_alpha   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: bin counting and passband sum
  plm_front #(
    .BINS           (BINS),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_we   (cfg_we),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mag   (s_tdata),
    .in_last  (s_tlast),
    .push     (push),
    .push_sum (push_sum),
    .q_full   (q_full)
  );

  // frame sums waiting for the back end
  plm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_sum),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  // back: log2, dBm level, attack/decay averagers, output register
  plm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_level   (out_level),
    .out_density (out_density),
    .out_present (out_present)
  );

  assign m_tdata = {5'b0, out_present, out_density, out_level};
endmodule
`default_nettype wire

### test/tb_passband_signal_level_meter_core.sv
`timescale 1ns / 1ps
module tb_passband_signal_level_meter_core;
  import plm_pkg::*;

  localparam int NBINS = 256;
  localparam int RATE = 96000;
  localparam int BACK_LAT = 100;
  localparam logic [ADDR_W-1:0] SPARE_IDX = 3'd7;  // no register behind it

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [MAG_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  passband_signal_level_meter_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [16:0] dbm;
    logic signed [16:0] density;
    bit present;
  } meter_reading_t;

  meter_reading_t readings_due[$];
  int fails = 0;
  int items_sent = 0;
  int frames_done = 0;
  int snd_idle = 35;
  int rcv_idle = 48;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  // shadow of the meter's registers and state
  cfg_t shadow;
  int unsigned bin_idx;
  longint unsigned acc_sum;
  longint atk_lvl, dec_lvl, atk_dens, dec_dens;

  function automatic longint div_round(longint num, longint w);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag * 2 + w) / (2 * w);
    return (num < 0) ? -mag : mag;
  endfunction

  // log2 in Q16: leading one, then 16 squarings of the Q1.30 mantissa
  function automatic longint unsigned log2_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic longint smooth(longint avg, longint x, logic [15:0] a);
    longint al;
    al = longint'(a);
    return ((65536 - al) * avg + al * x + 32768) >>> 16;
  endfunction

  function automatic logic signed [16:0] to_q98(longint q916);
    longint v;
    v = (q916 + 128) >>> 8;
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[16:0];
  endfunction

  task automatic meter_reset();
    shadow = '0;
    shadow.cal = 16'sd768;
    shadow.atk_alpha = 16'd26214;
    shadow.dec_alpha = 16'd3277;
    bin_idx = 0;
    acc_sum = 0;
    atk_lvl = -73 * 65536;
    dec_lvl = -73 * 65536;
    atk_dens = -103 * 65536;
    dec_dens = -103 * 65536;
  endtask

  // one accepted bin; returns 1 with the reading when it closes a frame
  function automatic bit meter_bin(input logic [23:0] mag, input bit last,
                                   output meter_reading_t rd);
    longint w, a, b, lo, hi, lq8, dq8;
    longint unsigned t;
    w = RATE / NBINS;
    if (w < 1) w = 1;
    case (shadow.demod_mode)
      MODE_USB: begin a = -shadow.filter_high; b = -shadow.filter_low; end
      MODE_LSB: begin a = shadow.filter_low; b = shadow.filter_high; end
      default: begin a = -shadow.filter_high; b = shadow.filter_high; end
    endcase
    lo = NBINS / 4 + div_round(a, w);
    hi = NBINS / 4 + div_round(b, w);
    if (lo < 0) lo = 0;
    if (hi > NBINS - 1) hi = NBINS - 1;
    if (lo == hi) hi = lo + 1;            // single-bin band widened to two bins
    if (longint'(bin_idx) >= lo && longint'(bin_idx) <= hi)
      acc_sum = (acc_sum + mag) & 64'hF_FFFF_FFFF;
    if (!last) begin
      if (bin_idx < NBINS - 1) bin_idx++;  // overlong frame sticks at top bin
      return 1'b0;
    end
    rd.present = (acc_sum != 0);
    if (rd.present) begin
      t = (log2_fix(acc_sum) * 197283 + (64'd1 << 23)) >> 24;
      lq8 = longint'(shadow.cal) + longint'(shadow.atten) * 256 + longint'(t)
            - longint'(Q816_OFFSET) + longint'(CONS_Q8);
      dq8 = 0;
    end else begin
      lq8 = longint'(QUIET_LVL_Q8);
      dq8 = longint'(QUIET_DENS_Q8);
    end
    atk_lvl = smooth(atk_lvl, lq8 * 256, shadow.atk_alpha);
    dec_lvl = smooth(dec_lvl, lq8 * 256, shadow.dec_alpha);
    atk_dens = smooth(atk_dens, dq8 * 256, shadow.atk_alpha);
    dec_dens = smooth(dec_dens, dq8 * 256, shadow.dec_alpha);
    if (atk_lvl > dec_lvl) dec_lvl = atk_lvl;     // decay snaps up to attack
    if (atk_dens > dec_dens) dec_dens = atk_dens;
    rd.dbm = to_q98(dec_lvl);
    rd.density = to_q98(dec_dens);
    bin_idx = 0;
    acc_sum = 0;
    return 1'b1;
  endfunction

  function automatic void shadow_write(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_DEMOD: shadow.demod_mode = d[1:0];
      REG_FHIGH: shadow.filter_high = d;
      REG_FLOW:  shadow.filter_low = d;
      REG_CAL:   shadow.cal = d[15:0];
      REG_ATTEN: shadow.atten = d[7:0];
      REG_ATK:   shadow.atk_alpha = d[15:0];
      REG_DEC:   shadow.dec_alpha = d[15:0];
      default: ;
    endcase
  endfunction

  // present < 0: no typed value, predictor only
  task automatic send_bin(logic [23:0] mag, bit last, int present = -1);
    meter_reading_t rd;
    if ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= mag;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (meter_bin(mag, last, rd)) begin
      if (present >= 0) rd.present = present[0];
      readings_due.push_back(rd);
      frames_done++;
    end
  endtask

  // registers change only with the block idle
  task automatic write_regs(logic [ADDR_W-1:0] idx[], int vals[]);
    s_tvalid <= 1'b0;
    wait (readings_due.size() == 0);
    repeat (BACK_LAT) @(posedge clk);
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= vals[i][CFG_W-1:0];
      shadow_write(idx[i], vals[i][CFG_W-1:0]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic program_meter(int mode, int fh, int fl, int cal, int att, int atk, int dec);
    logic [ADDR_W-1:0] idx[];
    int vals[];
    idx = '{REG_DEMOD, REG_FHIGH, REG_FLOW, REG_CAL, REG_ATTEN, REG_ATK, REG_DEC};
    vals = '{mode, fh, fl, cal, att, atk, dec};
    write_regs(idx, vals);
  endtask

  function automatic logic [23:0] pick_mag();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 110);
    for (int i = 1; i <= len; i++) send_bin(pick_mag(), i == len);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      m_tready <= 1'b0;
      hold_cnt <= 600;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // output checker: oldest expectation first
  always @(posedge clk) begin
    meter_reading_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (readings_due.size() == 0) begin
        $error("unexpected item on m_tdata: %h", m_tdata);
        fails++;
      end else begin
        e = readings_due.pop_front();
        if (m_tdata[16:0] !== e.dbm) begin
          $error("level_dbm exp %0d got %0d", e.dbm, $signed(m_tdata[16:0]));
          fails++;
        end
        if (m_tdata[33:17] !== e.density) begin
          $error("level_density exp %0d got %0d", e.density, $signed(m_tdata[33:17]));
          fails++;
        end
        if (m_tdata[34] !== e.present) begin
          $error("signal_present exp %0d got %0d", e.present, m_tdata[34]);
          fails++;
        end
      end
    end
  end

  typedef struct {
    logic [23:0] mag;
    bit last;
    int present;
  } bin_row_t;

  // directed bins, band covering bins 0..192
  bin_row_t dir_rows[] = '{
    '{24'hFFFFFF, 1'b1, 1}, '{24'h000000, 1'b1, 0}, '{24'h000001, 1'b1, 1},
    '{24'h000000, 1'b1, 0}, '{24'h800000, 1'b0, -1}, '{24'hFFFFFF, 1'b0, -1},
    '{24'h000000, 1'b0, -1}, '{24'h123456, 1'b1, 1}, '{24'h555555, 1'b0, -1},
    '{24'hAAAAAA, 1'b1, 1}, '{24'h000000, 1'b0, -1}, '{24'h000000, 1'b1, 0},
    '{24'h000002, 1'b1, 1}, '{24'hFFFFFF, 1'b1, 1}, '{24'h0000FF, 1'b1, 1}
  };

  initial begin
    logic [ADDR_W-1:0] sidx[];
    int svals[];
    meter_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part: first frame under reset registers, band at bins 64..65
    send_bin(24'hFFFFFF, 1'b1, 0);
    program_meter(MODE_DSB, 48000, 0, 768, 0, 26214, 3277);
    foreach (dir_rows[i]) send_bin(dir_rows[i].mag, dir_rows[i].last, dir_rows[i].present);
    sidx = '{SPARE_IDX};
    svals = '{17'h1ABCD};
    write_regs(sidx, svals);          // unused index, ignored

    for (int ph = 0; ph < 12 || items_sent < 1550 || frames_done < 30; ph++) begin
      if (ph == 4) begin snd_idle = 48; rcv_idle = 35; end
      if (ph == 8) begin snd_idle = 0; rcv_idle = 0; end
      case (ph)
        0: program_meter(MODE_USB, 48000, -48000, -32768, -128, 0, 65535);
        1: program_meter(MODE_LSB, 48000, -48000, 32767, 127, 65535, 0);
        2: program_meter(3, -48000, 48000, 0, 0, 65535, 65535);
        3: program_meter(MODE_USB, 0, 0, 768, 0, 0, 0);
        default: program_meter($urandom_range(3),
                               $urandom_range(0, 6000) - 3000,
                               $urandom_range(0, 6000) - 3000,
                               $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 255) - 128,
                               $urandom_range(65535), $urandom_range(65535));
      endcase
      if (ph == 9) begin
        // long receiver hold-off while bins keep coming
        hold_req <= 1'b1;
        send_bin(pick_mag(), 1'b1);
        hold_req <= 1'b0;
      end
      for (int n = 0; n < 55; ) begin
        int before_cnt;
        before_cnt = items_sent;
        send_frame();
        n += items_sent - before_cnt;
      end
    end
    s_tvalid <= 1'b0;
    wait (readings_due.size() == 0);
    repeat (BACK_LAT) @(posedge clk);
    if (fails == 0) begin
      $display("passband_signal_level_meter_core verification clean");
    end else begin
      $display("passband_signal_level_meter_core verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("passband_signal_level_meter_core verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/plm_pkg.sv
hdl/plm_queue.sv
hdl/plm_front.sv
hdl/plm_back.sv
hdl/passband_signal_level_meter_core.sv
test/tb_passband_signal_level_meter_core.sv
